### rtl/core/hsv_color_light_detector_assert.svh
// ----------------------------------------------------------------------------
// hsv_color_light_detector_assert.svh - assertion macros
// Wrappers for concurrent checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_LIGHT_DETECTOR_ASSERT_SVH
`define HSV_COLOR_LIGHT_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HCLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcld check failed");
// next-cycle implication
`define HCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcld check failed");
`else
`define HCLD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/hcld_pkg.sv
// ----------------------------------------------------------------------------
// hcld_pkg - shared types and constants
// Request and result records, light and outcome codes, register indexes.
// ----------------------------------------------------------------------------
package hcld_pkg;

    typedef enum logic [1:0] {
        LIGHT_NONE  = 2'd0,
        LIGHT_RED   = 2'd1,
        LIGHT_GREEN = 2'd2
    } light_t;

    typedef enum logic [1:0] {
        OUTCOME_RUNNING = 2'd0,
        OUTCOME_SUCCESS = 2'd1,
        OUTCOME_TIMEOUT = 2'd2
    } outcome_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROI_WINDOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HUE_BANDS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_SAT_VAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HSV       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_FRAMES  = 3'd6;

    localparam logic [47:0] ROI_WINDOW_RST      = 48'd4124511109240;
    localparam logic [31:0] RED_HUE_BANDS_RST   = 32'd3031042560;
    localparam logic [31:0] RED_SAT_VAL_RST     = 32'd4284809060;
    localparam logic [47:0] GREEN_HSV_RST       = 48'd280809246576680;
    localparam logic [23:0] RED_THRESHOLD_RST   = 24'd100;
    localparam logic [23:0] GREEN_THRESHOLD_RST = 24'd100;
    localparam logic [7:0]  CONFIRM_FRAMES_RST  = 8'd10;
    localparam logic [15:0] TIMEOUT_LIMIT_RST   = 16'd300;

    // classified request, front to back
    typedef struct packed {
        logic        start;
        logic        red_hit;
        logic        green_hit;
        logic        frame_end;
        logic [15:0] timeout;
    } req_t;

    // per-frame result
    typedef struct packed {
        light_t      light;
        logic [23:0] red_count;
        logic [23:0] green_count;
        logic        confirmed;
        outcome_t    outcome;
        logic        stop_drive;
    } res_t;

    // back stage handshake and status
    typedef struct packed {
        logic req_pop;
        logic res_push;
        logic run_active;
    } back_ctl_t;

    function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

### rtl/core/hcld_fifo.sv
// ----------------------------------------------------------------------------
// hcld_fifo - small register queue
// Power-of-two depth, first-word fall-through read.
// ----------------------------------------------------------------------------
module hcld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_CNT = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/hcld_front.sv
// ----------------------------------------------------------------------------
// hcld_front - pixel classifier
// Window test and red / green HSV box tests; resolves the run timeout.
// ----------------------------------------------------------------------------
module hcld_front #(
    parameter int COORD_BITS             = 12,
    parameter int DEFAULT_TIMEOUT_FRAMES = 300
) (
    input  logic                  cmd,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic [7:0]            hue,
    input  logic [7:0]            saturation,
    input  logic [7:0]            brightness,
    input  logic                  frame_end,
    input  logic [15:0]           timeout_frames,
    input  logic [47:0]           roi_window,
    input  logic [31:0]           red_hue_bands,
    input  logic [31:0]           red_sat_val_bounds,
    input  logic [47:0]           green_hsv_bounds,
    output hcld_pkg::req_t        req
);
    import hcld_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int ROI_W = (4 * C > 48) ? 4 * C : 48;
    localparam logic [15:0] DEF_TIMEOUT = 16'(DEFAULT_TIMEOUT_FRAMES);

    logic [ROI_W-1:0] roi_pad;
    logic [C-1:0]     wx, wy, ww, wh;
    logic [C:0]       x_end, y_end;
    logic             in_win;
    logic             red_hue, red_sv, green_box;

    // fields above bit 47 read as zero
    assign roi_pad = ROI_W'(roi_window);
    assign wx = roi_pad[0 +: C];
    assign wy = roi_pad[C +: C];
    assign ww = roi_pad[2*C +: C];
    assign wh = roi_pad[3*C +: C];

    assign x_end  = {1'b0, wx} + {1'b0, ww};
    assign y_end  = {1'b0, wy} + {1'b0, wh};
    assign in_win = (pixel_x >= wx) && ({1'b0, pixel_x} < x_end) &&
                    (pixel_y >= wy) && ({1'b0, pixel_y} < y_end);

    assign red_hue = in_range(hue, red_hue_bands[7:0], red_hue_bands[15:8]) ||
                     in_range(hue, red_hue_bands[23:16], red_hue_bands[31:24]);
    assign red_sv  = in_range(saturation, red_sat_val_bounds[7:0], red_sat_val_bounds[15:8]) &&
                     in_range(brightness, red_sat_val_bounds[23:16],
                              red_sat_val_bounds[31:24]);
    assign green_box = in_range(hue, green_hsv_bounds[7:0], green_hsv_bounds[15:8]) &&
                       in_range(saturation, green_hsv_bounds[23:16], green_hsv_bounds[31:24]) &&
                       in_range(brightness, green_hsv_bounds[39:32], green_hsv_bounds[47:40]);

    always_comb
    begin
        req.start     = (cmd == CMD_START);
        req.red_hit   = in_win && red_hue && red_sv;
        req.green_hit = in_win && green_box;
        req.frame_end = frame_end;
        req.timeout   = (timeout_frames != 16'd0) ? timeout_frames : DEF_TIMEOUT;
    end

endmodule

### rtl/core/hcld_back.sv
// ----------------------------------------------------------------------------
// hcld_back - run control and frame evaluation
// Tallies hits, decides the light per frame, tracks green age and timeout.
// ----------------------------------------------------------------------------
module hcld_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  hcld_pkg::req_t      req,
    input  logic                res_ready,
    input  logic [23:0]         red_count_threshold,
    input  logic [23:0]         green_count_threshold,
    input  logic [7:0]          confirm_frames,
    output hcld_pkg::res_t      res,
    output hcld_pkg::back_ctl_t ctl
);
    import hcld_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    logic                  run_active_reg, run_active_next;
    light_t                light_reg, light_next;
    logic [7:0]            green_age_reg, green_age_next;
    logic                  confirmed_reg, confirmed_next;
    logic [15:0]           frames_reg, frames_next;
    logic [15:0]           limit_reg, limit_next;
    logic [COUNT_BITS-1:0] red_tally_reg, red_tally_next;
    logic [COUNT_BITS-1:0] green_tally_reg, green_tally_next;

    logic [COUNT_BITS-1:0] red_t, green_t;
    logic                  red_over, green_over;
    outcome_t              outcome;

    // hit counts including the current pixel, saturating
    assign red_t   = (req.red_hit && red_tally_reg != TALLY_MAX) ?
                     red_tally_reg + 1'b1 : red_tally_reg;
    assign green_t = (req.green_hit && green_tally_reg != TALLY_MAX) ?
                     green_tally_reg + 1'b1 : green_tally_reg;
    assign red_over   = CMP_W'(red_t) > CMP_W'(red_count_threshold);
    assign green_over = CMP_W'(green_t) > CMP_W'(green_count_threshold);

    always_comb
    begin
        run_active_next  = run_active_reg;
        light_next       = light_reg;
        green_age_next   = green_age_reg;
        confirmed_next   = confirmed_reg;
        frames_next      = frames_reg;
        limit_next       = limit_reg;
        red_tally_next   = red_tally_reg;
        green_tally_next = green_tally_reg;
        outcome          = OUTCOME_RUNNING;
        ctl.req_pop      = req_valid && res_ready;
        ctl.res_push     = 1'b0;
        ctl.run_active   = run_active_reg;

        if (ctl.req_pop)
        begin
            if (req.start)
            begin
                run_active_next  = 1'b1;
                light_next       = LIGHT_NONE;
                green_age_next   = 8'd0;
                confirmed_next   = 1'b0;
                frames_next      = 16'd0;
                limit_next       = req.timeout;
                red_tally_next   = '0;
                green_tally_next = '0;
            end
            else if (run_active_reg)
            begin
                red_tally_next   = red_t;
                green_tally_next = green_t;
                if (req.frame_end)
                begin
                    frames_next = (frames_reg == 16'hFFFF) ? frames_reg : frames_reg + 16'd1;
                    if (red_over)
                    begin
                        light_next     = LIGHT_RED;
                        green_age_next = 8'd0;
                        confirmed_next = 1'b0;
                    end
                    else if (green_over)
                    begin
                        if (light_reg != LIGHT_GREEN)
                        begin
                            green_age_next = 8'd0;
                            confirmed_next = 1'b0;
                        end
                        else
                        begin
                            green_age_next = (green_age_reg == 8'hFF) ?
                                             green_age_reg : green_age_reg + 8'd1;
                        end
                        light_next = LIGHT_GREEN;
                        if (green_age_next >= confirm_frames)
                        begin
                            confirmed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        light_next     = LIGHT_NONE;
                        green_age_next = 8'd0;
                        confirmed_next = 1'b0;
                    end

                    if (light_next == LIGHT_GREEN && confirmed_next)
                    begin
                        outcome = OUTCOME_SUCCESS;
                    end
                    else if (light_next == LIGHT_NONE && frames_next > limit_reg)
                    begin
                        outcome = OUTCOME_TIMEOUT;
                    end

                    ctl.res_push     = 1'b1;
                    red_tally_next   = '0;
                    green_tally_next = '0;
                    if (outcome != OUTCOME_RUNNING)
                    begin
                        run_active_next = 1'b0;
                    end
                end
            end
        end

        res.light       = light_next;
        res.red_count   = 24'(red_t);
        res.green_count = 24'(green_t);
        res.confirmed   = confirmed_next;
        res.outcome     = outcome;
        res.stop_drive  = (light_next == LIGHT_RED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg  <= 1'b0;
            light_reg       <= LIGHT_NONE;
            green_age_reg   <= 8'd0;
            confirmed_reg   <= 1'b0;
            frames_reg      <= 16'd0;
            limit_reg       <= TIMEOUT_LIMIT_RST;
            red_tally_reg   <= '0;
            green_tally_reg <= '0;
        end
        else
        begin
            run_active_reg  <= run_active_next;
            light_reg       <= light_next;
            green_age_reg   <= green_age_next;
            confirmed_reg   <= confirmed_next;
            frames_reg      <= frames_next;
            limit_reg       <= limit_next;
            red_tally_reg   <= red_tally_next;
            green_tally_reg <= green_tally_next;
        end
    end

endmodule

### rtl/core/hsv_color_light_detector.sv
// ----------------------------------------------------------------------------
// hsv_color_light_detector - traffic light detector over an HSV pixel stream
// Counts red and green pixels in a window and reports the light per frame.
// ----------------------------------------------------------------------------
// The block takes one request per clock while full is low: a start request
// (cmd = 1) that opens a detection run and loads its frame timeout, or a
// pixel request carrying coordinates and H, S, V bytes. The classifier tests
// each pixel against the window and the color boxes as it is accepted; the
// result goes into a four-entry queue, and the run controller behind it
// tallies hits and, on the pixel flagged frame_end, produces one result:
// light state, both counts, green confirmation, outcome and stop_drive.
// Sustained rate is one request per clock while the result queue has room;
// a result is written to the result queue as its frame_end request leaves
// the request queue. A two-entry result queue lets the controller keep
// running while a result waits for pop. Pixels outside a run are consumed
// with no result. Configuration writes take effect on the next clock and
// must be made while no request is in flight.
// ----------------------------------------------------------------------------
`include "hsv_color_light_detector_assert.svh"

module hsv_color_light_detector #(
    parameter int COORD_BITS             = 12,
    parameter int COUNT_BITS             = 24,
    parameter int DEFAULT_TIMEOUT_FRAMES = 300
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  logic                            cmd,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    input  logic [7:0]                      hue,
    input  logic [7:0]                      saturation,
    input  logic [7:0]                      brightness,
    input  logic                            frame_end,
    input  logic [15:0]                     timeout_frames,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      light_state,
    output logic [23:0]                     red_count,
    output logic [23:0]                     green_count,
    output logic                            green_confirmed,
    output logic [1:0]                      outcome,
    output logic                            stop_drive,
    // configuration
    input  logic                            cfg_write,
    input  logic [hcld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcld_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hcld_pkg::*;

    localparam int REQ_W     = $bits(req_t);
    localparam int RES_W     = $bits(res_t);
    localparam int REQ_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // configuration registers
    logic [47:0] roi_window_reg;
    logic [31:0] red_hue_bands_reg;
    logic [31:0] red_sat_val_reg;
    logic [47:0] green_hsv_reg;
    logic [23:0] red_thr_reg;
    logic [23:0] green_thr_reg;
    logic [7:0]  confirm_frames_reg;

    req_t             front_req;
    req_t             mid_req;
    logic [REQ_W-1:0] mid_rd_data;
    logic             mid_empty;
    logic             mid_full;

    res_t             back_res;
    res_t             out_res;
    logic [RES_W-1:0] out_rd_data;
    logic             out_full;
    back_ctl_t        back_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_window_reg     <= ROI_WINDOW_RST;
            red_hue_bands_reg  <= RED_HUE_BANDS_RST;
            red_sat_val_reg    <= RED_SAT_VAL_RST;
            green_hsv_reg      <= GREEN_HSV_RST;
            red_thr_reg        <= RED_THRESHOLD_RST;
            green_thr_reg      <= GREEN_THRESHOLD_RST;
            confirm_frames_reg <= CONFIRM_FRAMES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROI_WINDOW:      roi_window_reg     <= cfg_data;
                CFG_RED_HUE_BANDS:   red_hue_bands_reg  <= cfg_data[31:0];
                CFG_RED_SAT_VAL:     red_sat_val_reg    <= cfg_data[31:0];
                CFG_GREEN_HSV:       green_hsv_reg      <= cfg_data;
                CFG_RED_THRESHOLD:   red_thr_reg        <= cfg_data[23:0];
                CFG_GREEN_THRESHOLD: green_thr_reg      <= cfg_data[23:0];
                CFG_CONFIRM_FRAMES:  confirm_frames_reg <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // front: classify on acceptance
    hcld_front #(
        .COORD_BITS             (COORD_BITS),
        .DEFAULT_TIMEOUT_FRAMES (DEFAULT_TIMEOUT_FRAMES)
    ) u_front (
        .cmd                (cmd),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .hue                (hue),
        .saturation         (saturation),
        .brightness         (brightness),
        .frame_end          (frame_end),
        .timeout_frames     (timeout_frames),
        .roi_window         (roi_window_reg),
        .red_hue_bands      (red_hue_bands_reg),
        .red_sat_val_bounds (red_sat_val_reg),
        .green_hsv_bounds   (green_hsv_reg),
        .req                (front_req)
    );

    // classified requests waiting for the controller
    hcld_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (REQ_DEPTH)
    ) u_req_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_req),
        .rd_en   (back_ctl.req_pop),
        .rd_data (mid_rd_data),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    assign full    = mid_full;
    assign mid_req = req_t'(mid_rd_data);

    // back: run control
    hcld_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .req_valid             (!mid_empty),
        .req                   (mid_req),
        .res_ready             (!out_full),
        .red_count_threshold   (red_thr_reg),
        .green_count_threshold (green_thr_reg),
        .confirm_frames        (confirm_frames_reg),
        .res                   (back_res),
        .ctl                   (back_ctl)
    );

    // finished results waiting for pop
    hcld_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_ctl.res_push),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (out_full),
        .empty   (empty)
    );

    assign out_res         = res_t'(out_rd_data);
    assign light_state     = out_res.light;
    assign red_count       = out_res.red_count;
    assign green_count     = out_res.green_count;
    assign green_confirmed = out_res.confirmed;
    assign outcome         = out_res.outcome;
    assign stop_drive      = out_res.stop_drive;

    // controller only moves a request when a result slot is free
    `HCLD_ASSERT_NOW(a_res_room, clk, rst_n, back_ctl.res_push, !out_full && back_ctl.req_pop)
    // controller never reads an empty request queue
    `HCLD_ASSERT_NOW(a_req_present, clk, rst_n, back_ctl.req_pop, !mid_empty)
    // a final result closes the run
    `HCLD_ASSERT_NEXT(a_run_closed, clk, rst_n,
        back_ctl.res_push && back_res.outcome != OUTCOME_RUNNING, !back_ctl.run_active)
    // a start request opens the run
    `HCLD_ASSERT_NEXT(a_run_opened, clk, rst_n,
        back_ctl.req_pop && mid_req.start, back_ctl.run_active)

endmodule

### dv/hsv_color_light_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_light_detector_test - self-checking bench for the light detector
// Streams start and pixel requests through the detector, predicts each frame
// report in step with accepted requests, and checks every report popped.
// ----------------------------------------------------------------------------
// Layout:
//   - main initial block: reset, directed requests, a backpressure phase,
//     then random phases, each under a fresh register setting
//   - driver (negedge): offers requests from pixel_stream
//   - accept block (posedge): runs the frame predictor on each accepted request
//   - receiver (negedge): pops with random stalls and one long hold-off
//   - monitor (posedge): compares each popped report with the oldest expected
// ----------------------------------------------------------------------------
module hsv_color_light_detector_test;
    import hcld_pkg::*;

    localparam int ITEM_TARGET   = 1750;
    localparam int HOLD_CYCLES   = 400;   // receiver hold-off, long enough to fill the block
    localparam int SETTLE_CYCLES = 12;    // pixels with no report may still be in flight
    localparam int DRAIN_LIMIT   = 5000;

    // what a generated pixel aims at
    typedef enum int {PAINT_NONE, PAINT_RED, PAINT_GREEN} paint_t;

    typedef struct {
        logic        cmd;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  h;
        logic [7:0]  s;
        logic [7:0]  v;
        logic        last;
        logic [15:0] tmo;
    } pixel_req_t;

    typedef struct {
        light_t      light;
        logic [23:0] red_n;
        logic [23:0] green_n;
        logic        confirmed;
        outcome_t    outcome;
        logic        stop;
    } frame_report_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 push            = 1'b0;
    logic                 full;
    logic                 cmd             = CMD_PIXEL;
    logic [11:0]          pixel_x         = '0;
    logic [11:0]          pixel_y         = '0;
    logic [7:0]           hue             = '0;
    logic [7:0]           saturation      = '0;
    logic [7:0]           brightness      = '0;
    logic                 frame_end       = 1'b0;
    logic [15:0]          timeout_frames  = '0;
    logic                 empty;
    logic                 pop             = 1'b0;
    logic [1:0]           light_state;
    logic [23:0]          red_count;
    logic [23:0]          green_count;
    logic                 green_confirmed;
    logic [1:0]           outcome;
    logic                 stop_drive;
    logic                 cfg_write       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_ROI_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    hsv_color_light_detector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .cmd             (cmd),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .hue             (hue),
        .saturation      (saturation),
        .brightness      (brightness),
        .frame_end       (frame_end),
        .timeout_frames  (timeout_frames),
        .empty           (empty),
        .pop             (pop),
        .light_state     (light_state),
        .red_count       (red_count),
        .green_count     (green_count),
        .green_confirmed (green_confirmed),
        .outcome         (outcome),
        .stop_drive      (stop_drive),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor copy of the registers (updated when the bench writes them)
    // ------------------------------------------------------------------------
    logic [47:0] roi          = ROI_WINDOW_RST;      // {h, w, y, x}
    logic [31:0] red_hue      = RED_HUE_BANDS_RST;   // {hi2, lo2, hi1, lo1}
    logic [31:0] red_sv       = RED_SAT_VAL_RST;     // {v hi, v lo, s hi, s lo}
    logic [47:0] green_box    = GREEN_HSV_RST;       // {v hi, v lo, s hi, s lo, h hi, h lo}
    logic [23:0] red_limit    = RED_THRESHOLD_RST;
    logic [23:0] green_limit  = GREEN_THRESHOLD_RST;
    logic [7:0]  confirm_need = CONFIRM_FRAMES_RST;

    // predictor copy of the run state
    bit          running      = 1'b0;
    light_t      light_now    = LIGHT_NONE;
    logic [7:0]  green_age    = '0;
    bit          confirmed    = 1'b0;
    logic [15:0] frame_count  = '0;
    logic [15:0] frame_limit  = TIMEOUT_LIMIT_RST;
    logic [23:0] red_tally    = '0;
    logic [23:0] green_tally  = '0;

    // bench bookkeeping
    pixel_req_t    pixel_stream[$];      // requests not yet offered
    frame_report_t expected_reports[$];  // reports predicted, not yet popped
    pixel_req_t    on_wire;              // request currently on the input ports
    frame_report_t want;
    int            offered_n    = 0;
    int            accepted_n   = 0;
    int            items_queued = 0;
    int            failures     = 0;
    int            cycle_n      = 0;
    bit            steady       = 1'b0;  // no random idling on either side while set
    int            hold_asked   = 0;
    int            hold_given   = 0;
    int            hold_left    = 0;

    // ------------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------------
    function automatic bit in_band(logic [7:0] val, logic [7:0] lo, logic [7:0] hi);
        return val >= lo && val <= hi;
    endfunction

    // window edges are compared without wrap: x + width may pass 4095
    function automatic bit in_roi(logic [11:0] px, logic [11:0] py);
        int wx, wy, ww, wh;
        wx = int'(roi[11:0]);
        wy = int'(roi[23:12]);
        ww = int'(roi[35:24]);
        wh = int'(roi[47:36]);
        return int'(px) >= wx && int'(px) < wx + ww && int'(py) >= wy && int'(py) < wy + wh;
    endfunction

    task automatic predict_frame_report(input pixel_req_t r);
        bit            red_px;
        bit            green_px;
        frame_report_t rep;
        if (r.cmd == CMD_START)
        begin
            // start (or restart): clear the run and load the timeout
            light_now   = LIGHT_NONE;
            green_age   = '0;
            confirmed   = 1'b0;
            frame_count = '0;
            red_tally   = '0;
            green_tally = '0;
            frame_limit = (r.tmo != 16'd0) ? r.tmo : TIMEOUT_LIMIT_RST;
            running     = 1'b1;
            return;
        end
        if (!running)
            return;
        if (in_roi(r.x, r.y))
        begin
            red_px = (in_band(r.h, red_hue[7:0], red_hue[15:8]) ||
                      in_band(r.h, red_hue[23:16], red_hue[31:24])) &&
                     in_band(r.s, red_sv[7:0], red_sv[15:8]) &&
                     in_band(r.v, red_sv[23:16], red_sv[31:24]);
            green_px = in_band(r.h, green_box[7:0], green_box[15:8]) &&
                       in_band(r.s, green_box[23:16], green_box[31:24]) &&
                       in_band(r.v, green_box[39:32], green_box[47:40]);
            if (red_px && red_tally != '1)
                red_tally++;
            if (green_px && green_tally != '1)
                green_tally++;
        end
        if (!r.last)
            return;

        // frame end: the last pixel is already counted
        if (frame_count != '1)
            frame_count++;
        if (red_tally > red_limit)
        begin
            light_now = LIGHT_RED;
            green_age = '0;
            confirmed = 1'b0;
        end
        else if (green_tally > green_limit)
        begin
            if (light_now != LIGHT_GREEN)
            begin
                green_age = '0;
                confirmed = 1'b0;
            end
            else if (green_age != '1)
                green_age++;
            light_now = LIGHT_GREEN;
            if (green_age >= confirm_need)
                confirmed = 1'b1;
        end
        else
        begin
            light_now = LIGHT_NONE;
            green_age = '0;
            confirmed = 1'b0;
        end

        rep.outcome = OUTCOME_RUNNING;
        if (light_now == LIGHT_GREEN && confirmed)
            rep.outcome = OUTCOME_SUCCESS;
        else if (light_now == LIGHT_NONE && frame_count > frame_limit)
            rep.outcome = OUTCOME_TIMEOUT;
        rep.light     = light_now;
        rep.red_n     = red_tally;
        rep.green_n   = green_tally;
        rep.confirmed = confirmed;
        rep.stop      = (light_now == LIGHT_RED);
        expected_reports.push_back(rep);

        red_tally   = '0;
        green_tally = '0;
        if (rep.outcome != OUTCOME_RUNNING)
            running = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Register writes (only while the block is idle)
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ROI_WINDOW:      roi          = data;
            CFG_RED_HUE_BANDS:   red_hue      = data[31:0];
            CFG_RED_SAT_VAL:     red_sv       = data[31:0];
            CFG_GREEN_HSV:       green_box    = data;
            CFG_RED_THRESHOLD:   red_limit    = data[23:0];
            CFG_GREEN_THRESHOLD: green_limit  = data[23:0];
            CFG_CONFIRM_FRAMES:  confirm_need = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [47:0] window, input logic [31:0] hue_bands,
                                    input logic [31:0] sat_val, input logic [47:0] green_v,
                                    input logic [23:0] red_thr, input logic [23:0] green_thr,
                                    input logic [7:0] confirm_v);
        write_register(CFG_ROI_WINDOW, window);
        write_register(CFG_RED_HUE_BANDS, {16'd0, hue_bands});
        write_register(CFG_RED_SAT_VAL, {16'd0, sat_val});
        write_register(CFG_GREEN_HSV, green_v);
        write_register(CFG_RED_THRESHOLD, {24'd0, red_thr});
        write_register(CFG_GREEN_THRESHOLD, {24'd0, green_thr});
        write_register(CFG_CONFIRM_FRAMES, {40'd0, confirm_v});
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random settings
    // ------------------------------------------------------------------------
    // {hi, lo}: full range, inverted (never matches), single value, or a band
    function automatic logic [15:0] rand_bounds(input int top);
        int k, lo, hi;
        k = $urandom_range(0, 9);
        case (k)
            0:
            begin
                lo = 0;
                hi = 255;
            end
            1:
            begin
                lo = $urandom_range(1, 255);
                hi = $urandom_range(0, lo - 1);
            end
            2:
            begin
                lo = $urandom_range(0, top);
                hi = lo;
            end
            default:
            begin
                lo = $urandom_range(0, top);
                hi = $urandom_range(lo, top);
            end
        endcase
        return {hi[7:0], lo[7:0]};
    endfunction

    function automatic logic [47:0] rand_window();
        int          k;
        logic [11:0] x, y, w, h;
        k = $urandom_range(0, 5);
        case (k)
            0:
            begin
                x = 12'd0;
                y = 12'd0;
                w = 12'd4095;
                h = 12'd4095;
            end
            1:
            begin
                // empty window
                x = 12'($urandom_range(0, 4095));
                y = 12'($urandom_range(0, 4095));
                w = 12'd0;
                h = 12'($urandom_range(0, 4095));
            end
            2:
            begin
                // far corner; x + width runs past the coordinate range
                x = 12'd4095;
                y = 12'd4095;
                w = 12'($urandom_range(1, 4095));
                h = 12'($urandom_range(1, 4095));
            end
            default:
            begin
                x = 12'($urandom_range(0, 3000));
                y = 12'($urandom_range(0, 3000));
                w = 12'($urandom_range(1, 400));
                h = 12'($urandom_range(1, 400));
            end
        endcase
        return {h, w, y, x};
    endfunction

    // small thresholds so short frames reach RED and GREEN
    function automatic logic [23:0] rand_limit();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 24'hFFFFFF;
        else if (k == 1)
            return 24'($urandom_range(24'hFFFFFF, 4));
        return 24'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] rand_confirm();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 8'd255;
        return 8'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    // a level inside [lo, hi], weighted toward the edges and just past them
    function automatic logic [7:0] pick_level(input logic [7:0] lo, input logic [7:0] hi);
        int k;
        if (lo > hi)
            return 8'($urandom_range(0, 255));
        k = $urandom_range(0, 9);
        case (k)
            0: return lo;
            1: return hi;
            2: return (lo == 8'd0) ? lo : lo - 8'd1;
            3: return (hi == 8'hFF) ? hi : hi + 8'd1;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    // mostly inside [base, base + span), with the window edges favored
    function automatic logic [11:0] pick_coord(input logic [11:0] base, input logic [11:0] span);
        int b, sp, c, k;
        b  = int'(base);
        sp = int'(span);
        if (sp == 0 || $urandom_range(0, 99) < 15)
            return 12'($urandom_range(0, 4095));
        k = $urandom_range(0, 9);
        case (k)
            0: c = b;
            1: c = b + sp - 1;
            2: c = b - 1;
            3: c = b + sp;
            default: c = b + int'($urandom_range(0, sp - 1));
        endcase
        if (c < 0)
            c = 0;
        if (c > 4095)
            c = 4095;
        return c[11:0];
    endfunction

    // fully random request; hue sometimes past 180
    function automatic pixel_req_t noise_req();
        pixel_req_t r;
        r.cmd  = ($urandom_range(0, 3) == 0) ? CMD_START : CMD_PIXEL;
        r.x    = 12'($urandom_range(0, 4095));
        r.y    = 12'($urandom_range(0, 4095));
        r.h    = $urandom_range(0, 1) ? 8'($urandom_range(0, 180)) : 8'($urandom_range(0, 255));
        r.s    = 8'($urandom_range(0, 255));
        r.v    = 8'($urandom_range(0, 255));
        r.last = 1'($urandom_range(0, 1));
        r.tmo  = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic pixel_req_t start_req(input logic [15:0] tmo);
        pixel_req_t r;
        r     = noise_req();
        r.cmd = CMD_START;
        r.tmo = tmo;
        return r;
    endfunction

    function automatic pixel_req_t make_pixel(input int x, input int y, input int h, input int s,
                                              input int v, input logic last);
        pixel_req_t r;
        r      = noise_req();
        r.cmd  = CMD_PIXEL;
        r.x    = 12'(x);
        r.y    = 12'(y);
        r.h    = 8'(h);
        r.s    = 8'(s);
        r.v    = 8'(v);
        r.last = last;
        return r;
    endfunction

    function automatic paint_t random_paint();
        return paint_t'($urandom_range(0, 2));
    endfunction

    function automatic pixel_req_t color_pixel(input paint_t paint, input logic last);
        pixel_req_t r;
        r      = noise_req();
        r.cmd  = CMD_PIXEL;
        r.last = last;
        r.x    = pick_coord(roi[11:0], roi[35:24]);
        r.y    = pick_coord(roi[23:12], roi[47:36]);
        case (paint)
            PAINT_RED:
            begin
                if ($urandom_range(0, 1))
                    r.h = pick_level(red_hue[7:0], red_hue[15:8]);
                else
                    r.h = pick_level(red_hue[23:16], red_hue[31:24]);
                r.s = pick_level(red_sv[7:0], red_sv[15:8]);
                r.v = pick_level(red_sv[23:16], red_sv[31:24]);
            end
            PAINT_GREEN:
            begin
                r.h = pick_level(green_box[7:0], green_box[15:8]);
                r.s = pick_level(green_box[23:16], green_box[31:24]);
                r.v = pick_level(green_box[39:32], green_box[47:40]);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic enqueue(input pixel_req_t r);
        pixel_stream.push_back(r);
        items_queued++;
    endtask

    // one run: start, a few frames leaning toward one color, some noise mixed in
    task automatic queue_run();
        int          k, frames, len;
        logic [15:0] tmo;
        paint_t      bias, dom;
        k = $urandom_range(0, 19);
        if (k < 11)
            tmo = 16'($urandom_range(1, 6));
        else if (k < 14)
            tmo = 16'($urandom_range(7, 40));
        else if (k < 16)
            tmo = 16'd0;
        else if (k < 18)
            tmo = 16'hFFFF;
        else
            tmo = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0)
            enqueue(noise_req());
        enqueue(start_req(tmo));
        bias   = $urandom_range(0, 1) ? PAINT_GREEN : random_paint();
        frames = $urandom_range(1, 10);
        for (int f = 0; f < frames; f++)
        begin
            dom = ($urandom_range(0, 3) == 0) ? random_paint() : bias;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            for (int p = 0; p < len; p++)
                enqueue(color_pixel(($urandom_range(0, 9) < 7) ? dom : random_paint(),
                                    p == len - 1));
            if ($urandom_range(0, 19) == 0)
                enqueue(noise_req());
        end
    endtask

    // ------------------------------------------------------------------------
    // Wait for the block to go idle: everything offered, accepted and reported
    // ------------------------------------------------------------------------
    function automatic bit work_pending();
        return pixel_stream.size() != 0 || offered_n != accepted_n ||
               expected_reports.size() != 0;
    endfunction

    task automatic drain(input int settle);
        int spins;
        spins = 0;
        while (work_pending() && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (work_pending())
        begin
            $error("block stuck: %0d requests unsent, %0d reports missing",
                   pixel_stream.size(), expected_reports.size());
            failures++;
            expected_reports.delete();
        end
        repeat (settle) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: inputs change on the falling edge; a request stays up until taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (accepted_n == offered_n)
        begin
            if (pixel_stream.size() == 0 || (!steady && $urandom_range(0, 99) < 7))
                push <= 1'b0;
            else
            begin
                on_wire = pixel_stream.pop_front();
                offered_n++;
                push           <= 1'b1;
                cmd            <= on_wire.cmd;
                pixel_x        <= on_wire.x;
                pixel_y        <= on_wire.y;
                hue            <= on_wire.h;
                saturation     <= on_wire.s;
                brightness     <= on_wire.v;
                frame_end      <= on_wire.last;
                timeout_frames <= on_wire.tmo;
            end
        end
    end

    // accept: a request is taken when push is high and full is low at the edge
    always @(posedge clk)
    begin
        cycle_n++;
        // a recurring idle-free stretch, late in each period of cycle_n
        steady = (cycle_n % 3000) >= 2200;
        if (rst_n && push && !full)
        begin
            predict_frame_report(on_wire);
            accepted_n++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random pop stalls, plus a long hold-off when one is asked for
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (hold_asked != hold_given)
        begin
            hold_given = hold_asked;
            hold_left  = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= steady || $urandom_range(0, 99) >= 7;
    end

    // ------------------------------------------------------------------------
    // Monitor: each popped report against the oldest expected one
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report popped with none expected: light_state %0d outcome %0d",
                       light_state, outcome);
                failures++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("light_state", 24'(want.light), 24'(light_state));
                check_field("red_count", want.red_n, red_count);
                check_field("green_count", want.green_n, green_count);
                check_field("green_confirmed", 24'(want.confirmed), 24'(green_confirmed));
                check_field("outcome", 24'(want.outcome), 24'(outcome));
                check_field("stop_drive", 24'(want.stop), 24'(stop_drive));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: window x 120..199, y 80..139; red hue 0-10
        // and 170-180, S/V 100-255; green H 40-80, S/V 100-255; thresholds 100.
        enqueue(make_pixel(150, 100, 5, 200, 200, 1'b1));     // no run yet: ignored
        enqueue(start_req(16'd2));
        enqueue(make_pixel(120, 80, 0, 100, 100, 1'b0));      // red, window corner, low bounds
        enqueue(make_pixel(199, 139, 180, 255, 255, 1'b0));   // red, far corner, top bounds
        enqueue(make_pixel(200, 100, 10, 200, 200, 1'b0));    // just right of window
        enqueue(make_pixel(119, 100, 10, 200, 200, 1'b0));    // just left of window
        enqueue(make_pixel(150, 79, 170, 200, 200, 1'b0));    // just above window
        enqueue(make_pixel(150, 140, 170, 200, 200, 1'b0));   // just below window
        enqueue(make_pixel(150, 100, 11, 255, 255, 1'b0));    // between the red bands
        enqueue(make_pixel(150, 100, 169, 99, 100, 1'b0));    // below band two, sat too low
        enqueue(make_pixel(150, 100, 40, 100, 100, 1'b0));    // green, low bounds
        enqueue(make_pixel(150, 100, 80, 255, 255, 1'b1));    // green, top bounds; frame 1
        enqueue(make_pixel(4095, 4095, 255, 0, 0, 1'b1));     // frame 2, not past timeout
        enqueue(make_pixel(0, 0, 81, 99, 99, 1'b1));          // frame 3 with no light: timeout
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // run over: ignored
        enqueue(start_req(16'd0));                            // zero picks the default timeout
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));
        enqueue(start_req(16'hFFFF));                         // restart in the middle of a run
        enqueue(make_pixel(150, 100, 39, 200, 99, 1'b1));
        drain(SETTLE_CYCLES);

        // Directed, one pixel is enough: light sequence and green confirmation
        program_settings(ROI_WINDOW_RST, RED_HUE_BANDS_RST, RED_SAT_VAL_RST, GREEN_HSV_RST,
                         24'd0, 24'd0, 8'd1);
        enqueue(start_req(16'd3));
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // green, first frame, unconfirmed
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b0));
        enqueue(make_pixel(150, 100, 5, 200, 200, 1'b1));     // red and green: red wins
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // green again, age restarts
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // persisted: confirmed, success
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // run ended: ignored
        drain(SETTLE_CYCLES);
        program_settings(ROI_WINDOW_RST, RED_HUE_BANDS_RST, RED_SAT_VAL_RST, GREEN_HSV_RST,
                         24'd0, 24'd0, 8'd0);
        enqueue(start_req(16'd5));
        enqueue(make_pixel(150, 100, 60, 200, 200, 1'b1));    // confirmed on the first frame
        drain(SETTLE_CYCLES);

        // Backpressure: the receiver holds off while one-pixel frames keep coming,
        // so the result side fills and full rises. Max thresholds keep the light
        // off, so the default timeout ends the run after frame 301.
        program_settings({12'd4095, 12'd4095, 12'd0, 12'd0}, {rand_bounds(180), rand_bounds(180)},
                         {rand_bounds(255), rand_bounds(255)},
                         {rand_bounds(255), rand_bounds(255), rand_bounds(180)},
                         24'hFFFFFF, 24'hFFFFFF, 8'd255);
        hold_asked++;
        enqueue(start_req(16'd0));
        repeat (305) enqueue(color_pixel(random_paint(), 1'b1));

        // Random phases; each drains (the sender waits for every report) and
        // then loads a new setting.
        while (items_queued < ITEM_TARGET)
        begin
            drain(SETTLE_CYCLES);
            program_settings(rand_window(), {rand_bounds(180), rand_bounds(180)},
                             {rand_bounds(255), rand_bounds(255)},
                             {rand_bounds(255), rand_bounds(255), rand_bounds(180)},
                             rand_limit(), rand_limit(), rand_confirm());
            repeat ($urandom_range(2, 5)) queue_run();
        end

        drain(SETTLE_CYCLES + 8);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/hcld_pkg.sv
rtl/core/hcld_fifo.sv
rtl/core/hcld_front.sv
rtl/core/hcld_back.sv
rtl/core/hsv_color_light_detector.sv
dv/hsv_color_light_detector_test.sv
